// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
// both expect signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, cond)
`endif

`endif

// ===== rtl/bas_pkg.sv =====
package bas_pkg;

  localparam int IDX_W = 11;
  localparam int VAL_W = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic signed [IDX_W-1:0] NOT_FOUND = -11'sd1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_MISS,
    RES_MID,
    RES_OVF
  } res_t;

  typedef struct packed {
    logic idle;
    logic clear;
    logic append;
    logic key_load;
    logic setup;
    logic probe;
    logic step;
    logic out_load;
    res_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic rd_eq;
    logic range_empty;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/bas_ram.sv =====
module bas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bas_ctrl.sv =====
`include "assert_macros.svh"

module bas_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     opcode,
  input  bas_pkg::sts_t  sts,
  output bas_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t        state;
  bas_pkg::res_t res_sel;
  logic          accept;

  assign accept = (state == S_IDLE) && in_valid;

  always_comb begin
    cmd          = '0;
    cmd.idle     = (state == S_IDLE);
    cmd.res_sel  = res_sel;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            bas_pkg::OP_CLEAR:  cmd.clear    = 1'b1;
            bas_pkg::OP_APPEND: cmd.append   = !sts.full;
            bas_pkg::OP_QUERY:  cmd.key_load = 1'b1;
            default: ;
          endcase
        end
      end
      S_FIRST: cmd.setup    = !sts.rd_eq;
      S_PROBE: cmd.probe    = !sts.range_empty;
      S_CHECK: cmd.step     = !sts.rd_eq;
      S_DONE:  cmd.out_load = sts.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      res_sel <= bas_pkg::RES_MISS;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              bas_pkg::OP_APPEND: begin
                if (sts.full) begin
                  res_sel <= bas_pkg::RES_OVF;
                  state   <= S_DONE;
                end
              end
              bas_pkg::OP_QUERY: begin
                if (sts.empty) begin
                  res_sel <= bas_pkg::RES_MISS;
                  state   <= S_DONE;
                end else begin
                  state <= S_FIRST;
                end
              end
              default: ;
            endcase
          end
        end
        S_FIRST: begin
          if (sts.rd_eq) begin
            res_sel <= bas_pkg::RES_ZERO;
            state   <= S_DONE;
          end else begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (sts.range_empty) begin
            res_sel <= bas_pkg::RES_MISS;
            state   <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.rd_eq) begin
            res_sel <= bas_pkg::RES_MID;
            state   <= S_DONE;
          end else begin
            state <= S_PROBE;
          end
        end
        S_DONE: begin
          if (sts.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_check_after_probe, (state == S_CHECK) |-> ($past(state) == S_PROBE))
  `ASSERT_NEVER(a_append_when_full, cmd.append && sts.full)
  `ASSERT_PROP(a_done_releases, (state == S_DONE) && sts.slot_free |=> (state == S_IDLE))

endmodule

// ===== rtl/bas_dp.sv =====
`include "assert_macros.svh"

module bas_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [bas_pkg::VAL_W-1:0]          value,
  input  logic                               out_ready,
  input  bas_pkg::cmd_t                      cmd,
  output bas_pkg::sts_t                      sts,
  output logic                               out_valid,
  output logic signed [bas_pkg::IDX_W-1:0]   found_index,
  output logic                               overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (AW > bas_pkg::IDX_W) ? AW : bas_pkg::IDX_W;

  logic [CW-1:0]               count;
  logic [bas_pkg::VAL_W-1:0]   peak;
  logic [CW-1:0]               turn_index;
  logic                        turn_seen;
  logic [bas_pkg::VAL_W-1:0]   key;
  logic [CW-1:0]               lo;
  logic [CW-1:0]               hi;
  logic                        rising;
  logic [AW-1:0]               mid;

  logic [CW-1:0]               split;
  logic [CW:0]                 mid_sum;
  logic [AW-1:0]               mid_calc;
  logic [AW-1:0]               raddr;
  logic [bas_pkg::VAL_W-1:0]   rdata;
  logic                        rd_gt;
  logic                        wr_en;
  logic [XW-1:0]               mid_x;
  logic signed [bas_pkg::IDX_W-1:0] res_index;
  logic                        res_ovf;

  // falling part starts at the turn, or is empty when the run never fell
  assign split    = turn_seen ? turn_index : count;
  // hi is exclusive, so the midpoint is floor((lo + hi - 1) / 2)
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - (CW + 1)'(1);
  assign mid_calc = mid_sum[AW:1];
  assign raddr    = cmd.probe ? mid_calc : '0;
  assign rd_gt    = rdata > key;
  assign wr_en    = cmd.append;

  bas_ram #(
    .WIDTH(bas_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[AW-1:0]),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.empty       = (count == '0);
  assign sts.full        = (count == CW'(DEPTH));
  assign sts.rd_eq       = (rdata == key);
  assign sts.range_empty = (lo >= hi);
  assign sts.slot_free   = !out_valid || out_ready;

  assign mid_x = XW'(mid);

  always_comb begin
    case (cmd.res_sel)
      bas_pkg::RES_ZERO: begin
        res_index = '0;
        res_ovf   = 1'b0;
      end
      bas_pkg::RES_MID: begin
        res_index = mid_x[bas_pkg::IDX_W-1:0];
        res_ovf   = 1'b0;
      end
      bas_pkg::RES_OVF: begin
        res_index = bas_pkg::NOT_FOUND;
        res_ovf   = 1'b1;
      end
      default: begin
        res_index = bas_pkg::NOT_FOUND;
        res_ovf   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      peak       <= '0;
      turn_index <= '0;
      turn_seen  <= 1'b0;
      lo         <= '0;
      hi         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count      <= '0;
        peak       <= '0;
        turn_index <= '0;
        turn_seen  <= 1'b0;
      end else if (cmd.append) begin
        if ((count == '0) || (value > peak)) begin
          peak <= value;
        end else if (!turn_seen) begin
          turn_seen  <= 1'b1;
          turn_index <= count;
        end
        count <= count + CW'(1);
      end
      if (cmd.setup) begin
        if (rd_gt) begin
          lo <= split;
          hi <= count;
        end else begin
          lo <= '0;
          hi <= split;
        end
      end else if (cmd.step) begin
        if (rd_gt == rising) begin
          hi <= CW'(mid);
        end else begin
          lo <= CW'(mid) + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= value;
    end
    if (cmd.setup) begin
      rising <= !rd_gt;
    end
    if (cmd.probe) begin
      mid <= mid_calc;
    end
    if (cmd.out_load) begin
      found_index <= res_index;
      overflow    <= res_ovf;
    end
  end

  `ASSERT_NEVER(a_count_range, count > CW'(DEPTH))
  `ASSERT_NEVER(a_window_order, lo > hi)
  `ASSERT_PROP(a_turn_below_count, turn_seen |-> (turn_index < count))

endmodule

// ===== rtl/bitonic_array_search.sv =====
// bitonic array search: holds up to DEPTH 32-bit elements appended in order
// and meant to rise strictly and then fall, and answers index lookups.
// opcode 0 clears the store, 1 appends value, 2 looks value up; opcode 3
// is taken and ignored. clear and append give no output beat, except an
// append to a full store, which is dropped and gives found_index -1 with
// overflow 1. a query always gives one beat: the index of the key, or -1.
// the first position whose element is not above the running peak is the
// turn; a key below element 0 is searched in the falling part, a key above
// it in the rising part, a key equal to it answers 0.
// flow: clear and an append that fits keep in_ready high. a query holds
// in_ready low until its answer is loaded; a key equal to element 0 needs
// no probe, any other key at most clog2(DEPTH) + 1 probes, and a query of
// an empty store goes straight to the answer. each probe has two steps
// because the element memory has a registered read: one state sends the
// midpoint address, the next compares the returned element. an overflowing
// append holds in_ready low as well. waiting for a busy output register
// lengthens these holds. the final beat waits in the output register
// while out_ready is low; clear and append beats are still taken while it
// waits, a query or an overflow waits for the slot.
// no clearing pass after reset: the element count alone decides which
// entries are live.
module bitonic_array_search #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [bas_pkg::VAL_W-1:0]        value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bas_pkg::IDX_W-1:0] found_index,
  output logic                             overflow
);

  // command and status between the sequencer and the datapath
  bas_pkg::cmd_t cmd;
  bas_pkg::sts_t sts;

  // the block takes a beat only while the sequencer is idle
  assign in_ready = cmd.idle;

  bas_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .opcode  (opcode),
    .sts     (sts),
    .cmd     (cmd)
  );

  // element store, peak and turn tracking, search window and output register
  bas_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .found_index(found_index),
    .overflow   (overflow)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  // opcode 3 is taken by the block and ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // longest run of cycles with no beat on either side before giving up;
  // the slowest correct stretch is the long hold-off plus one lookup
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  // time left for any late beat before the final check
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 36;

  typedef struct packed {
    logic signed [bas_pkg::IDX_W-1:0] idx;
    logic                             ovf;
  } answer_t;

  // shadow of the element store plus the queue of answers still owed
  class index_tracker;
    logic [bas_pkg::VAL_W-1:0] elems [DEPTH];
    int                        count;
    logic [bas_pkg::VAL_W-1:0] peak;
    int                        turn;
    bit                        turn_seen;
    answer_t                   owed[$];
    int                        errors;
    int                        lookups;
    int                        hits;
    int                        drops;
    int                        beats;

    function void flag(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    function void empty_store();
      count = 0;
      peak = '0;
      turn = 0;
      turn_seen = 0;
    endfunction

    // binary search of one monotonic run over [lo, hi]
    function int search_run(int lo, int hi, logic [bas_pkg::VAL_W-1:0] key, bit rising);
      int mid;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (elems[mid] == key) return mid;
        if ((elems[mid] > key) == rising) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    function void take_beat(logic [1:0] op, logic [bas_pkg::VAL_W-1:0] val);
      answer_t a;
      int      split;
      int      ans;
      beats++;
      case (op)
        bas_pkg::OP_CLEAR: empty_store();
        bas_pkg::OP_APPEND: begin
          if (count >= DEPTH) begin
            a.idx = bas_pkg::NOT_FOUND;
            a.ovf = 1'b1;
            owed.push_back(a);
            drops++;
          end else begin
            elems[count] = val;
            if (count == 0 || val > peak) begin
              peak = val;
            end else if (!turn_seen) begin
              turn_seen = 1;
              turn = count;
            end
            count++;
          end
        end
        bas_pkg::OP_QUERY: begin
          lookups++;
          if (count == 0) begin
            ans = -1;
          end else begin
            split = turn_seen ? turn : count;
            if (val < elems[0]) ans = search_run(split, count - 1, val, 0);
            else if (val == elems[0]) ans = 0;
            else ans = search_run(0, split - 1, val, 1);
          end
          if (ans >= 0) hits++;
          a.idx = ans[bas_pkg::IDX_W-1:0];
          a.ovf = 1'b0;
          owed.push_back(a);
        end
        default: ;
      endcase
    endfunction

    function void match_answer(logic signed [bas_pkg::IDX_W-1:0] idx, logic ovf);
      answer_t e;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected output beat: found_index %0d, overflow %0b", idx, ovf));
        return;
      end
      e = owed.pop_front();
      if (idx !== e.idx)
        flag($sformatf("found_index: expected %0d, got %0d", $signed(e.idx), idx));
      if (ovf !== e.ovf)
        flag($sformatf("overflow: expected %0b, got %0b", e.ovf, ovf));
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       opcode = bas_pkg::OP_CLEAR;
  logic [bas_pkg::VAL_W-1:0]        value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [bas_pkg::IDX_W-1:0] found_index;
  logic                             overflow;

  index_tracker board = new;

  // idling knobs, in percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;
  // long receiver hold-off, requested at a rising edge, counted at falling edges
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent = 0;

  bitonic_array_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found_index(found_index),
    .overflow   (overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // monitor and watchdog: beats are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.match_answer(found_index, overflow);
      if (in_valid && in_ready) board.take_beat(opcode, value);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one input beat and hold it until it is taken
  task automatic send_item(logic [1:0] op, logic [bas_pkg::VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= val;
    do @(posedge clk); while (!in_ready);
    if (op != OP_UNUSED) sent++;
  endtask

  // stop offering and wait for every owed answer
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // lookup on the empty store right after reset
    send_item(bas_pkg::OP_QUERY, 32'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    // rising 5 9 max, then falling 7 0
    send_item(bas_pkg::OP_APPEND, 32'd5);
    send_item(bas_pkg::OP_APPEND, 32'd9);
    send_item(bas_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_item(bas_pkg::OP_APPEND, 32'd7);
    send_item(bas_pkg::OP_APPEND, 32'd0);
    send_item(bas_pkg::OP_QUERY, 32'd5);
    send_item(bas_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_item(bas_pkg::OP_QUERY, 32'd0);
    send_item(bas_pkg::OP_QUERY, 32'd7);
    send_item(bas_pkg::OP_QUERY, 32'd6);
    send_item(bas_pkg::OP_QUERY, 32'd10);
    // cleared store answers not found
    send_item(bas_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_item(bas_pkg::OP_QUERY, 32'd5);
    // never falls, first element zero still counts as rising
    send_item(bas_pkg::OP_APPEND, 32'd0);
    send_item(bas_pkg::OP_APPEND, 32'd1);
    send_item(bas_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_item(bas_pkg::OP_QUERY, 32'hFFFF_FFFF);
    // key below element 0 with an empty falling part
    send_item(bas_pkg::OP_CLEAR, 32'd0);
    send_item(bas_pkg::OP_APPEND, 32'd10);
    send_item(bas_pkg::OP_APPEND, 32'd20);
    send_item(bas_pkg::OP_QUERY, 32'd3);
    // repeated element marks the turn
    send_item(bas_pkg::OP_CLEAR, 32'd0);
    send_item(bas_pkg::OP_APPEND, 32'd4);
    send_item(bas_pkg::OP_APPEND, 32'd4);
    send_item(bas_pkg::OP_QUERY, 32'd4);
  endtask

  // fill the store to the top, then push past it
  task automatic run_full_store();
    logic [bas_pkg::VAL_W-1:0] vals [DEPTH];
    send_item(bas_pkg::OP_CLEAR, 32'd0);
    for (int i = 0; i < DEPTH; i++) begin
      if (i < 600) vals[i] = 32'hFFFF_0000 + i * 4;
      else vals[i] = 32'hFFFF_0000 + 599 * 4 - (i - 599) * 3;
      send_item(bas_pkg::OP_APPEND, vals[i]);
    end
    send_item(bas_pkg::OP_APPEND, 32'd0);
    send_item(bas_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_item(bas_pkg::OP_QUERY, vals[DEPTH-1]);
    send_item(bas_pkg::OP_APPEND, $urandom);
    send_item(bas_pkg::OP_QUERY, vals[0]);
    send_item(bas_pkg::OP_QUERY, vals[599]);
    send_item(bas_pkg::OP_QUERY, vals[600]);
    send_item(bas_pkg::OP_QUERY, vals[300]);
    send_item(bas_pkg::OP_QUERY, vals[DEPTH-1] - 1);
    send_item(bas_pkg::OP_QUERY, vals[599] + 1);
    send_item(bas_pkg::OP_QUERY, 32'd0);
    send_item(bas_pkg::OP_CLEAR, 32'd0);
  endtask

  // clear, append a rising-then-falling run, then look keys up;
  // a broken set spoils some elements with random values
  task automatic run_bitonic_set(bit broken);
    logic [bas_pkg::VAL_W-1:0] seq[$];
    logic [bas_pkg::VAL_W-1:0] cur;
    logic [bas_pkg::VAL_W-1:0] key;
    int                        up;
    int                        down;
    int                        step_max;
    int                        pick;
    seq = {};
    up = $urandom_range(1, 24);
    down = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    case ($urandom_range(0, 2))
      0: step_max = 3;
      1: step_max = 1000;
      default: step_max = 1 << 24;
    endcase
    cur = $urandom_range(32'h4000_0000, 32'hBFFF_FFFF);
    for (int i = 0; i < up; i++) begin
      seq.push_back(cur);
      cur += $urandom_range(1, step_max);
    end
    cur = seq[$];
    for (int i = 0; i < down; i++) begin
      cur -= $urandom_range(1, step_max);
      seq.push_back(cur);
    end
    if (broken) begin
      repeat ($urandom_range(1, 3)) seq[$urandom_range(0, seq.size() - 1)] = $urandom;
    end
    send_item(bas_pkg::OP_CLEAR, $urandom);
    foreach (seq[i]) send_item(bas_pkg::OP_APPEND, seq[i]);
    repeat ($urandom_range(2, 8)) begin
      pick = $urandom_range(0, 99);
      key = seq[$urandom_range(0, seq.size() - 1)];
      if (pick >= 80) key = $urandom;
      else if (pick >= 70) key = key + 1;
      else if (pick >= 60) key = key - 1;
      send_item(bas_pkg::OP_QUERY, key);
    end
  endtask

  task automatic run_phase(int idle, int stall);
    int start;
    int pick;
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    start = sent;
    while (sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        run_bitonic_set(0);
      end else if (pick < 88) begin
        run_bitonic_set(1);
      end else begin
        // loose beats of any kind
        repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 3)), $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    wait_drained();
    run_full_store();
    wait_drained();

    // hold the receiver off while lookups keep coming, so the block backs up
    send_item(bas_pkg::OP_APPEND, 32'd50);
    send_item(bas_pkg::OP_APPEND, 32'd80);
    send_item(bas_pkg::OP_APPEND, 32'd30);
    @(posedge clk);
    hold_req = 1;
    repeat (12) send_item(bas_pkg::OP_QUERY, $urandom_range(0, 99));
    wait_drained();

    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(23, 23);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.owed.size() != 0)
      board.flag($sformatf("%0d expected beats never arrived", board.owed.size()));

    $display("run covered %0d input beats, %0d lookups (%0d hits), %0d dropped appends",
             board.beats, board.lookups, board.hits, board.drops);
    $display("idling: none, sender, receiver, both, plus one long receiver hold-off");
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
